/* rtl/sfs_pkg.sv */
package sfs_pkg;

   localparam int TIMER_W    = 40;
   localparam int DT_W       = 24;
   localparam int SPEED_W    = 16;
   localparam int DUR_W      = 24;
   localparam int COUNT_W    = 9;
   localparam int MODE_W     = 2;
   localparam int FPOS_W     = 8;
   localparam int REQ_W      = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   // largest count the frame_count register can express
   localparam int COUNT_MAX  = 511;

   typedef enum logic [REQ_W-1:0] {
      REQ_TICK   = 3'd0,
      REQ_PLAY   = 3'd1,
      REQ_PAUSE  = 3'd2,
      REQ_RESUME = 3'd3,
      REQ_STOP   = 3'd4
   } sfs_req_type;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_COUNT    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_DURATION = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PLAYBACK_SPEED = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PLAY_MODE      = 2'd3;

   localparam logic [MODE_W-1:0] MODE_ONCE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_LOOP = 2'd1;

   // durations at or below this (about 0.0001 s) halt stepping
   localparam logic [DUR_W-1:0] MIN_DURATION = 24'd6;

   localparam logic [COUNT_W-1:0] RST_FRAME_COUNT    = 9'd0;
   localparam logic [DUR_W-1:0]   RST_FRAME_DURATION = 24'd6554;
   localparam logic [SPEED_W-1:0] RST_PLAYBACK_SPEED = 16'd256;
   localparam logic [MODE_W-1:0]  RST_PLAY_MODE      = MODE_LOOP;

   typedef struct packed {
      logic [COUNT_W-1:0] frame_count;
      logic [DUR_W-1:0]   frame_duration;
      logic [SPEED_W-1:0] playback_speed;
      logic [MODE_W-1:0]  play_mode;
   } sfs_cfg_type;

   typedef struct packed {
      logic running;
      logic backward;
   } sfs_flags_type;

endpackage

/* rtl/sprite_frame_sequencer_core.sv */
// Sprite animation frame sequencer. One request word (tick, play, pause, resume
// or stop) is taken per clock and each produces exactly one result word in the
// result register after the first stage, holding the frame position, running
// and reversing flags and whether the position moved. The first stage
// registers the request together with delta_time * playback_speed from the
// 24x16 multiplier; the second stage does the saturating timer add, the
// frame-duration compare and subtract and the position step, updates the state
// and loads the result register. Back-pressure on rsp_ready stalls both stages;
// otherwise the core sustains one word per cycle. Configuration writes must
// only be issued while no request is in flight.
module sprite_frame_sequencer_core import sfs_pkg::*; #(
   parameter int MAX_FRAMES = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [REQ_W-1:0]      req_type,
   input  logic [DT_W-1:0]       req_delta_time,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [FPOS_W-1:0]     rsp_frame_position,
   output logic                  rsp_is_playing,
   output logic                  rsp_is_reversing,
   output logic                  rsp_frame_advanced,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   localparam int NMAX  = (MAX_FRAMES < COUNT_MAX) ? MAX_FRAMES : COUNT_MAX;
   localparam int POS_W = $clog2(NMAX);

   sfs_cfg_type        cfg_ff;
   logic               s1_valid_ff;
   logic [REQ_W-1:0]   s1_req_ff;
   logic [TIMER_W-1:0] s1_step_ff;
   logic [TIMER_W-1:0] s1_step_in;
   logic               rsp_valid_ff;
   logic [FPOS_W-1:0]  rsp_pos_ff;
   logic               rsp_playing_ff;
   logic               rsp_reversing_ff;
   logic               rsp_advanced_ff;
   logic [TIMER_W-1:0] timer_ff;
   logic [TIMER_W-1:0] timer_in;
   logic [POS_W-1:0]   pos_ff;
   logic [POS_W-1:0]   pos_in;
   sfs_flags_type      flags_ff;
   sfs_flags_type      flags_in;
   logic               advanced;
   logic               out_free;
   logic               s1_adv;
   logic [COUNT_W-1:0] pos_wide;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign s1_adv     = s1_valid_ff && out_free;
   assign req_ready  = !s1_valid_ff || out_free;
   assign s1_step_in = TIMER_W'(req_delta_time) * TIMER_W'(cfg_ff.playback_speed);
   assign pos_wide   = COUNT_W'(pos_in);

   sfs_update #(
      .POS_W (POS_W),
      .NMAX  (NMAX)
   ) u_update (
      .req_code   (s1_req_ff),
      .step       (s1_step_ff),
      .cfg        (cfg_ff),
      .timer      (timer_ff),
      .pos        (pos_ff),
      .flags      (flags_ff),
      .timer_next (timer_in),
      .pos_next   (pos_in),
      .flags_next (flags_in),
      .advanced   (advanced)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_count    <= RST_FRAME_COUNT;
         cfg_ff.frame_duration <= RST_FRAME_DURATION;
         cfg_ff.playback_speed <= RST_PLAYBACK_SPEED;
         cfg_ff.play_mode      <= RST_PLAY_MODE;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_FRAME_COUNT:    cfg_ff.frame_count    <= csr_write_data[COUNT_W-1:0];
            CSR_FRAME_DURATION: cfg_ff.frame_duration <= csr_write_data[DUR_W-1:0];
            CSR_PLAYBACK_SPEED: cfg_ff.playback_speed <= csr_write_data[SPEED_W-1:0];
            CSR_PLAY_MODE:      cfg_ff.play_mode      <= csr_write_data[MODE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         timer_ff     <= '0;
         pos_ff       <= '0;
         flags_ff     <= '0;
      end else begin
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (out_free) begin
            rsp_valid_ff <= s1_valid_ff;
         end
         if (s1_adv) begin
            timer_ff <= timer_in;
            pos_ff   <= pos_in;
            flags_ff <= flags_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_req_ff  <= req_type;
         s1_step_ff <= s1_step_in;
      end
      if (s1_adv) begin
         rsp_pos_ff       <= pos_wide[FPOS_W-1:0];
         rsp_playing_ff   <= flags_in.running;
         rsp_reversing_ff <= flags_in.backward;
         rsp_advanced_ff  <= advanced;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_frame_position = rsp_pos_ff;
   assign rsp_is_playing     = rsp_playing_ff;
   assign rsp_is_reversing   = rsp_reversing_ff;
   assign rsp_frame_advanced = rsp_advanced_ff;

   // state only moves when a word leaves the first stage
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !s1_adv |=> $stable(timer_ff) && $stable(pos_ff) && $stable(flags_ff))
      else $error("sequencer state changed without a word");

   // a stalled first stage keeps its word
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_free |=> s1_valid_ff && $stable(s1_step_ff) && $stable(s1_req_ff))
      else $error("first stage lost a stalled word");

   // position stays inside the largest clip
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      COUNT_W'(pos_ff) < COUNT_W'(NMAX))
      else $error("frame position beyond clip limit");

   // the advanced flag of a result matches a real position change
   a_adv_flag: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> rsp_frame_advanced == (pos_ff != $past(pos_ff)))
      else $error("advanced flag disagrees with position");

endmodule

/* rtl/sfs_update.sv */
module sfs_update import sfs_pkg::*; #(
   parameter int POS_W = 8,
   parameter int NMAX  = 256
) (
   input  logic [REQ_W-1:0]   req_code,
   input  logic [TIMER_W-1:0] step,
   input  sfs_cfg_type        cfg,
   input  logic [TIMER_W-1:0] timer,
   input  logic [POS_W-1:0]   pos,
   input  sfs_flags_type      flags,
   output logic [TIMER_W-1:0] timer_next,
   output logic [POS_W-1:0]   pos_next,
   output sfs_flags_type      flags_next,
   output logic               advanced
);

   localparam logic [COUNT_W-1:0] NCAP = COUNT_W'(NMAX);

   logic [COUNT_W-1:0] n_eff;
   logic [COUNT_W-1:0] pos_w;
   logic [COUNT_W-1:0] pos_inc;
   logic [TIMER_W:0]   sum;
   logic [TIMER_W-1:0] timer_sat;
   logic [TIMER_W-1:0] dur;
   logic               halt;

   always_comb begin
      n_eff     = (cfg.frame_count > NCAP) ? NCAP : cfg.frame_count;
      pos_w     = COUNT_W'(pos);
      pos_inc   = pos_w + 9'd1;
      halt      = !flags.running || (cfg.playback_speed == '0) ||
                  (cfg.frame_duration <= MIN_DURATION) || (n_eff < 9'd2);
      sum       = {1'b0, timer} + {1'b0, step};
      timer_sat = sum[TIMER_W] ? {TIMER_W{1'b1}} : sum[TIMER_W-1:0];
      dur       = TIMER_W'({cfg.frame_duration, 8'd0});

      timer_next = timer;
      pos_next   = pos;
      flags_next = flags;

      case (req_code)
         REQ_TICK: begin
            if (!halt) begin
               if (timer_sat >= dur) begin
                  timer_next = timer_sat - dur;
                  if (cfg.play_mode[1]) begin
                     // ping-pong, mode three behaves the same
                     if (flags.backward) begin
                        if (pos_w != '0) begin
                           pos_next = POS_W'(pos_w - 9'd1);
                        end else begin
                           flags_next.backward = 1'b0;
                           pos_next = POS_W'(9'd1);
                        end
                     end else begin
                        if (pos_w < n_eff - 9'd1) begin
                           pos_next = POS_W'(pos_inc);
                        end else begin
                           flags_next.backward = 1'b1;
                           pos_next = POS_W'(n_eff - 9'd2);
                        end
                     end
                  end else begin
                     if (pos_inc >= n_eff) begin
                        if (cfg.play_mode == MODE_LOOP) begin
                           pos_next = '0;
                        end else begin
                           pos_next = POS_W'(n_eff - 9'd1);
                           flags_next.running = 1'b0;
                        end
                     end else begin
                        pos_next = POS_W'(pos_inc);
                     end
                  end
               end else begin
                  timer_next = timer_sat;
               end
            end
         end
         REQ_PLAY: begin
            pos_next   = '0;
            timer_next = '0;
            flags_next.running  = 1'b1;
            flags_next.backward = 1'b0;
         end
         REQ_PAUSE: begin
            flags_next.running = 1'b0;
         end
         REQ_RESUME: begin
            flags_next.running = 1'b1;
         end
         REQ_STOP: begin
            flags_next.running = 1'b0;
            pos_next   = '0;
            timer_next = '0;
         end
         default: begin
         end
      endcase

      advanced = (pos_next != pos);
   end

endmodule

/* tb/sprite_frame_sequencer_core_tb.sv */
`timescale 1ns / 1ps

module sprite_frame_sequencer_core_tb;
   import sfs_pkg::*;

   localparam int FRAME_LIMIT = 256;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [DT_W-1:0] DT_MAX = '1;
   localparam logic [MODE_W-1:0] MODE_PINGPONG = 2'd2;
   // fourth mode code behaves as ping-pong
   localparam logic [MODE_W-1:0] MODE_PINGPONG_ALT = 2'd3;
   localparam logic [REQ_W-1:0] REQ_UNKNOWN_LO = 3'd5;
   localparam logic [REQ_W-1:0] REQ_UNKNOWN_HI = 3'd7;

   typedef struct {
      logic [REQ_W-1:0] kind;
      logic [DT_W-1:0]  delta;
   } request_word_type;

   typedef struct {
      logic [FPOS_W-1:0] position;
      logic              playing;
      logic              reversing;
      logic              advanced;
   } frame_status_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [REQ_W-1:0] req_type = '0;
   logic [DT_W-1:0] req_delta_time = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [FPOS_W-1:0] rsp_frame_position;
   logic rsp_is_playing;
   logic rsp_is_reversing;
   logic rsp_frame_advanced;
   logic csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   // configuration as the block should hold it
   logic [COUNT_W-1:0] cfg_count = RST_FRAME_COUNT;
   logic [DUR_W-1:0] cfg_duration = RST_FRAME_DURATION;
   logic [SPEED_W-1:0] cfg_speed = RST_PLAYBACK_SPEED;
   logic [MODE_W-1:0] cfg_mode = RST_PLAY_MODE;

   // animation state tracked alongside the block
   logic [TIMER_W-1:0] anim_timer = '0;
   logic [FPOS_W-1:0] anim_position = '0;
   logic anim_running = 1'b0;
   logic anim_backward = 1'b0;

   request_word_type pending_words[$];
   frame_status_type frame_status_q[$];
   request_word_type next_word;
   frame_status_type seen;

   bit idle_enabled = 1'b1;
   int drv_gap = 0;
   int rsp_gap = 0;
   int cycle_count = 0;
   int mismatches = 0;
   int ticks_sent = 0;
   int commands_sent = 0;
   int unknown_sent = 0;
   int results_checked = 0;
   int frame_steps = 0;
   int settings_used = 0;

   sprite_frame_sequencer_core #(.MAX_FRAMES(FRAME_LIMIT)) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_type           (req_type),
      .req_delta_time     (req_delta_time),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_frame_position (rsp_frame_position),
      .rsp_is_playing     (rsp_is_playing),
      .rsp_is_reversing   (rsp_is_reversing),
      .rsp_frame_advanced (rsp_frame_advanced),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   always #5 clock = ~clock;

   // applies one request word to the tracked state and queues the status it yields
   task automatic step_animation(input logic [REQ_W-1:0] kind, input logic [DT_W-1:0] delta);
      logic [FPOS_W-1:0] prior;
      int unsigned frames;
      logic [TIMER_W:0] sum;
      logic [TIMER_W-1:0] dur_scaled;
      frame_status_type st;
      prior = anim_position;
      frames = (cfg_count > FRAME_LIMIT) ? FRAME_LIMIT : cfg_count;
      case (kind)
         REQ_TICK: begin
            if (anim_running && cfg_speed != 0 && cfg_duration > MIN_DURATION &&
                frames >= 2) begin
               sum = {1'b0, anim_timer} + (TIMER_W + 1)'(TIMER_W'(delta) * TIMER_W'(cfg_speed));
               anim_timer = sum[TIMER_W] ? '1 : sum[TIMER_W-1:0];
               dur_scaled = TIMER_W'(cfg_duration) << 8;
               if (anim_timer >= dur_scaled) begin
                  anim_timer = anim_timer - dur_scaled;
                  if (cfg_mode == MODE_PINGPONG || cfg_mode == MODE_PINGPONG_ALT) begin
                     if (anim_backward) begin
                        if (anim_position > 0) begin
                           anim_position = anim_position - 1'b1;
                        end else begin
                           anim_backward = 1'b0;
                           anim_position = 1;
                        end
                     end else if (anim_position < frames - 1) begin
                        anim_position = anim_position + 1'b1;
                     end else begin
                        anim_backward = 1'b1;
                        anim_position = FPOS_W'(frames - 2);
                     end
                  end else if (anim_position + 1 >= frames) begin
                     if (cfg_mode == MODE_LOOP) begin
                        anim_position = '0;
                     end else begin
                        anim_position = FPOS_W'(frames - 1);
                        anim_running = 1'b0;
                     end
                  end else begin
                     anim_position = anim_position + 1'b1;
                  end
               end
            end
         end
         REQ_PLAY: begin
            anim_position = '0;
            anim_timer = '0;
            anim_running = 1'b1;
            anim_backward = 1'b0;
         end
         REQ_PAUSE: anim_running = 1'b0;
         REQ_RESUME: anim_running = 1'b1;
         REQ_STOP: begin
            anim_running = 1'b0;
            anim_position = '0;
            anim_timer = '0;
         end
         default: ;
      endcase
      st.position = anim_position;
      st.playing = anim_running;
      st.reversing = anim_backward;
      st.advanced = (anim_position != prior);
      if (st.advanced) frame_steps++;
      frame_status_q.push_back(st);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            step_animation(req_type, req_delta_time);
            if (req_type == REQ_TICK) ticks_sent++;
            else if (req_type > REQ_STOP) unknown_sent++;
            else commands_sent++;
         end
         if (!req_valid || req_ready) begin
            if (drv_gap > 0) begin
               drv_gap--;
               req_valid <= 1'b0;
            end else if (pending_words.size() != 0) begin
               next_word = pending_words.pop_front();
               req_valid <= 1'b1;
               req_type <= next_word.kind;
               req_delta_time <= next_word.delta;
               if (idle_enabled && $urandom_range(0, 3) == 0) drv_gap = $urandom_range(1, 11);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor with random back-pressure
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            results_checked++;
            if (frame_status_q.size() == 0) begin
               $error("result word with nothing expected: position %0d", rsp_frame_position);
               mismatches++;
            end else begin
               seen = frame_status_q.pop_front();
               if (rsp_frame_position !== seen.position) begin
                  $error("frame_position: expected %0d, got %0d", seen.position,
                         rsp_frame_position);
                  mismatches++;
               end
               if (rsp_is_playing !== seen.playing) begin
                  $error("is_playing: expected %0b, got %0b", seen.playing, rsp_is_playing);
                  mismatches++;
               end
               if (rsp_is_reversing !== seen.reversing) begin
                  $error("is_reversing: expected %0b, got %0b", seen.reversing,
                         rsp_is_reversing);
                  mismatches++;
               end
               if (rsp_frame_advanced !== seen.advanced) begin
                  $error("frame_advanced: expected %0b, got %0b", seen.advanced,
                         rsp_frame_advanced);
                  mismatches++;
               end
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (idle_enabled && $urandom_range(0, 5) == 0) rsp_gap = $urandom_range(1, 11);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $error("run did not finish within %0d cycles", CYCLE_LIMIT);
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic queue_word(input logic [REQ_W-1:0] kind, input logic [DT_W-1:0] delta);
      request_word_type w;
      w.kind = kind;
      w.delta = delta;
      pending_words.push_back(w);
   endtask

   // tick lengths mostly around what one frame step needs at the current setting
   function automatic logic [DT_W-1:0] shaped_delta();
      longint unsigned need;
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (cfg_speed == 0) need = 2000;
      else need = 2 * ((64'(cfg_duration) << 8) + cfg_speed - 1) / cfg_speed;
      if (need > DT_MAX) need = DT_MAX;
      case (pick)
         0: return '0;
         1: return DT_MAX;
         2: return DT_W'($urandom());
         default: return DT_W'($urandom_range(0, 32'(need)));
      endcase
   endfunction

   task automatic queue_random_word();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 72) queue_word(REQ_TICK, shaped_delta());
      else if (pick < 80) queue_word(REQ_PLAY, DT_W'($urandom()));
      else if (pick < 85) queue_word(REQ_PAUSE, DT_W'($urandom()));
      else if (pick < 92) queue_word(REQ_RESUME, DT_W'($urandom()));
      else if (pick < 96) queue_word(REQ_STOP, DT_W'($urandom()));
      else queue_word(REQ_W'($urandom_range(REQ_UNKNOWN_LO, REQ_UNKNOWN_HI)),
                      DT_W'($urandom()));
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (pending_words.size() != 0 || req_valid || frame_status_q.size() != 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      case (idx)
         CSR_FRAME_COUNT: cfg_count = data[COUNT_W-1:0];
         CSR_FRAME_DURATION: cfg_duration = data[DUR_W-1:0];
         CSR_PLAYBACK_SPEED: cfg_speed = data[SPEED_W-1:0];
         CSR_PLAY_MODE: cfg_mode = data[MODE_W-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_clip(input int count, input int dur, input int speed,
                           input logic [MODE_W-1:0] mode);
      write_csr(CSR_FRAME_COUNT, CSR_DATA_W'(count));
      write_csr(CSR_FRAME_DURATION, CSR_DATA_W'(dur));
      write_csr(CSR_PLAYBACK_SPEED, CSR_DATA_W'(speed));
      write_csr(CSR_PLAY_MODE, CSR_DATA_W'(mode));
      settings_used++;
   endtask

   task automatic run_setting(input int count, input int dur, input int speed,
                              input logic [MODE_W-1:0] mode, input int words);
      set_clip(count, dur, speed, mode);
      queue_word(REQ_PLAY, '0);
      repeat (words) queue_random_word();
      wait_idle();
   endtask

   // walk the position up, then cut the clip below it without restarting
   task automatic shrink_clip(input logic [MODE_W-1:0] mode, input int count, input int steps,
                              input int words);
      set_clip(count, 100, 256, mode);
      queue_word(REQ_PLAY, '0);
      repeat (steps) queue_word(REQ_TICK, 24'd100);
      wait_idle();
      write_csr(CSR_FRAME_COUNT, CSR_DATA_W'(5));
      repeat (4) queue_word(REQ_TICK, 24'd100);
      repeat (words) queue_random_word();
      wait_idle();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset settings: empty clip, so ticks never step
      queue_word(REQ_TICK, DT_MAX);
      queue_word(REQ_PLAY, '0);
      queue_word(REQ_TICK, DT_MAX);
      queue_word(REQ_PAUSE, '0);
      queue_word(REQ_RESUME, DT_MAX);
      queue_word(REQ_STOP, '0);
      queue_word(REQ_TICK, '0);
      queue_word(REQ_UNKNOWN_LO, DT_MAX);
      queue_word(REQ_UNKNOWN_HI, '0);
      wait_idle();

      // shortest duration that still steps; loop wraps, partial ticks accumulate
      set_clip(4, 7, 256, MODE_LOOP);
      queue_word(REQ_PLAY, '0);
      repeat (5) queue_word(REQ_TICK, 24'd7);
      queue_word(REQ_TICK, 24'd6);
      queue_word(REQ_TICK, 24'd1);
      wait_idle();

      // full speed and full ticks saturate the timer; bouncing at both ends
      set_clip(3, 7, 65535, MODE_PINGPONG_ALT);
      queue_word(REQ_PLAY, '0);
      repeat (5) queue_word(REQ_TICK, DT_MAX);
      queue_word(REQ_PAUSE, '0);
      queue_word(REQ_TICK, DT_MAX);
      queue_word(REQ_RESUME, '0);
      queue_word(REQ_TICK, DT_MAX);
      wait_idle();

      run_setting(8, 6554, 256, MODE_LOOP, 35);
      run_setting(2, 7, 1, MODE_PINGPONG, 35);
      run_setting(256, 16777215, 65535, MODE_ONCE, 30);
      run_setting(511, 300, 512, MODE_PINGPONG, 30);
      run_setting(5, 1000, 256, MODE_ONCE, 35);
      run_setting(1, 1000, 256, MODE_LOOP, 20);
      run_setting(6, 6, 256, MODE_LOOP, 20);
      run_setting(6, 1000, 0, MODE_LOOP, 20);
      shrink_clip(MODE_LOOP, 40, 30, 10);
      shrink_clip(MODE_ONCE, 40, 30, 10);
      shrink_clip(MODE_PINGPONG, 40, 30, 10);
      shrink_clip(MODE_PINGPONG_ALT, 12, 16, 10);

      // closing stretch at full rate on both sides
      idle_enabled = 1'b0;
      run_setting(16, 50, 300, MODE_PINGPONG, 35);

      repeat (10) @(posedge clock);
      if (frame_status_q.size() != 0) begin
         $error("%0d expected result words never arrived", frame_status_q.size());
         mismatches++;
      end
      $display("covered %0d ticks, %0d playback commands and %0d unknown requests",
               ticks_sent, commands_sent, unknown_sent);
      $display("over %0d clip settings; checked %0d result words, %0d with a frame step",
               settings_used, results_checked, frame_steps);
      $display("%0d mismatches", mismatches);
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/sfs_pkg.sv
rtl/sfs_update.sv
rtl/sprite_frame_sequencer_core.sv
tb/sprite_frame_sequencer_core_tb.sv
